// ----- hdl/ping_pong_line_motion_generator_macros.svh -----
// ----------------------------------------------------------------------------
// ping_pong_line_motion_generator_macros
// assertion shorthands used by the port checker
// ----------------------------------------------------------------------------
`ifndef PING_PONG_LINE_MOTION_GENERATOR_MACROS_SVH
`define PING_PONG_LINE_MOTION_GENERATOR_MACROS_SVH

// same-cycle implication on clk, disabled in reset
`define PPLMG_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pplmg assertion failed");

// next-cycle implication on clk, disabled in reset
`define PPLMG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pplmg assertion failed");

`endif

// ----- hdl/pplmg_pkg.sv -----
// ----------------------------------------------------------------------------
// pplmg_pkg
// shared types and constants of the ping-pong line motion generator
// ----------------------------------------------------------------------------
package pplmg_pkg;

    localparam int unsigned JUMP_BACK_DEFAULT = 0;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_START_X      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Y      = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Z      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_X        = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_END_Y        = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_END_Z        = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT = 4'd7;

    localparam logic [23:0] HALF_PERIOD_RESET  = 24'd1000000;
    localparam logic [15:0] REPEAT_COUNT_RESET = 16'hFFFF;
    localparam logic [15:0] REPEAT_ENDLESS     = 16'hFFFF;
    localparam logic [16:0] PASSES_ENDLESS     = 17'h1FFFF;

    // remainder unit width: phase plus elapsed time
    localparam int unsigned REM_W = 26;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic  vld;
        axis_t axis;
    } lerp_tag_t;

endpackage

// ----- hdl/pplmg_cmpsub.sv -----
// ----------------------------------------------------------------------------
// pplmg_cmpsub
// shared compare-and-subtract step of the modulo and divide iterations
// ----------------------------------------------------------------------------
module pplmg_cmpsub (
    input  logic [pplmg_pkg::REM_W-1:0] cur,
    input  logic [pplmg_pkg::REM_W-1:0] divisor,
    output logic                        ge,
    output logic [pplmg_pkg::REM_W-1:0] rem
);

    logic [pplmg_pkg::REM_W:0] diff;

    assign diff = {1'b0, cur} - {1'b0, divisor};
    assign ge   = ~diff[pplmg_pkg::REM_W];
    assign rem  = ge ? diff[pplmg_pkg::REM_W-1:0] : cur;

endmodule

// ----- hdl/pplmg_lerp.sv -----
// ----------------------------------------------------------------------------
// pplmg_lerp
// three-stage interpolation pipe: a + floor((b - a) * t / 65536)
// ----------------------------------------------------------------------------
module pplmg_lerp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [31:0]   a,
    input  logic signed [31:0]   b,
    input  logic [16:0]          t,
    input  pplmg_pkg::lerp_tag_t tag_in,
    output logic signed [31:0]   pos,
    output pplmg_pkg::lerp_tag_t tag_out
);

    logic signed [32:0]   d_reg;
    logic signed [31:0]   a1_reg;
    logic signed [50:0]   prod_reg;
    logic signed [31:0]   a2_reg;
    logic signed [31:0]   pos_reg;
    pplmg_pkg::lerp_tag_t tag1_reg;
    pplmg_pkg::lerp_tag_t tag2_reg;
    pplmg_pkg::lerp_tag_t tag3_reg;

    logic signed [32:0]   d_next;
    logic signed [50:0]   prod_next;
    logic signed [31:0]   pos_next;

    assign d_next    = $signed({b[31], b}) - $signed({a[31], a});
    assign prod_next = d_reg * $signed({1'b0, t});
    // arithmetic shift by 16 keeps the floor for negative products
    assign pos_next  = a2_reg + $signed(prod_reg[47:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        a1_reg   <= a;
        prod_reg <= prod_next;
        a2_reg   <= a1_reg;
        pos_reg  <= pos_next;
    end

    assign pos     = pos_reg;
    assign tag_out = tag3_reg;

endmodule

// ----- hdl/ping_pong_line_motion_generator.sv -----
// ----------------------------------------------------------------------------
// ping_pong_line_motion_generator
// point moving back and forth along a 3d line, one position per time tick
// ----------------------------------------------------------------------------
// sequence: an input transfer runs the modulo steps, a setup step, the divide
//   steps, the interpolation and the output load; the modulo and divide steps
//   share the compare-subtract unit; an exhausted pass count skips to the load
// flow: ticks are taken one at a time; a held result does not block the next tick
// reset: registers take their documented defaults, motion restarts at phase 0
// ----------------------------------------------------------------------------
module ping_pong_line_motion_generator #(
    parameter int unsigned JUMP_BACK = pplmg_pkg::JUMP_BACK_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [pplmg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pplmg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [23:0]                         elapsed_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [31:0]                  pos_x,
    output logic signed [31:0]                  pos_y,
    output logic signed [31:0]                  pos_z,
    output logic                                position_valid,
    output logic                                finished
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_PREP,
        S_DIV,
        S_MUL,
        S_OUT
    } state_t;

    localparam logic [4:0] MOD_LAST = 5'(pplmg_pkg::REM_W - 1);
    localparam logic [4:0] DIV_LAST = 5'd16;
    localparam logic [4:0] MUL_FEED = 5'd3;

    state_t state_reg, state_next;

    logic [31:0] start_x_reg, start_x_next;
    logic [31:0] start_y_reg, start_y_next;
    logic [31:0] start_z_reg, start_z_next;
    logic [31:0] end_x_reg, end_x_next;
    logic [31:0] end_y_reg, end_y_next;
    logic [31:0] end_z_reg, end_z_next;
    logic [23:0] half_reg, half_next;
    logic [15:0] repeat_reg, repeat_next;

    logic [24:0] phase_reg, phase_next;
    logic        fwd_reg, fwd_next;
    logic [16:0] passes_reg, passes_next;

    logic [pplmg_pkg::REM_W-1:0] sum_reg, sum_next;
    logic [24:0] rem_reg, rem_next;
    logic [16:0] quot_reg, quot_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;
    logic [31:0] res_x_reg, res_x_next;
    logic [31:0] res_y_reg, res_y_next;
    logic [31:0] res_z_reg, res_z_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] pos_x_reg, pos_x_next;
    logic [31:0] pos_y_reg, pos_y_next;
    logic [31:0] pos_z_reg, pos_z_next;
    logic        pv_reg, pv_next;
    logic        fin_out_reg, fin_out_next;

    logic [23:0] h;
    logic [24:0] period;
    logic        endless;
    logic        dir;
    logic [24:0] num;
    logic        in_xfer;
    logic        out_load;

    logic [pplmg_pkg::REM_W-1:0] cs_cur;
    logic [pplmg_pkg::REM_W-1:0] cs_div;
    logic                        cs_ge;
    logic [pplmg_pkg::REM_W-1:0] cs_rem;

    logic signed [31:0]   lerp_a;
    logic signed [31:0]   lerp_b;
    logic signed [31:0]   lerp_pos;
    pplmg_pkg::lerp_tag_t lerp_tag_in;
    pplmg_pkg::lerp_tag_t lerp_tag_out;

    assign h       = (half_reg == '0) ? 24'd1 : half_reg;
    assign period  = {h, 1'b0};
    assign endless = (passes_reg == pplmg_pkg::PASSES_ENDLESS);
    assign dir     = (phase_reg <= {1'b0, h});
    assign num     = dir ? phase_reg
                   : ((JUMP_BACK != 0) ? (phase_reg - {1'b0, h}) : (period - phase_reg));
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // shared compare-subtract: modulo by the period, then divide by the half period
    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            cs_div = {2'b00, h};
            cs_cur = (cnt_reg == DIV_LAST) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        end
        else
        begin
            cs_div = {1'b0, period};
            cs_cur = {rem_reg, sum_reg[pplmg_pkg::REM_W-1]};
        end
    end

    pplmg_cmpsub u_cmpsub (
        .cur     (cs_cur),
        .divisor (cs_div),
        .ge      (cs_ge),
        .rem     (cs_rem)
    );

    always_comb
    begin
        lerp_tag_in.vld  = (state_reg == S_MUL) && (cnt_reg < MUL_FEED);
        lerp_tag_in.axis = pplmg_pkg::AXIS_X;
        lerp_a           = $signed(start_x_reg);
        lerp_b           = $signed(end_x_reg);
        case (cnt_reg[1:0])
            2'd1:
            begin
                lerp_tag_in.axis = pplmg_pkg::AXIS_Y;
                lerp_a           = $signed(start_y_reg);
                lerp_b           = $signed(end_y_reg);
            end
            2'd2:
            begin
                lerp_tag_in.axis = pplmg_pkg::AXIS_Z;
                lerp_a           = $signed(start_z_reg);
                lerp_b           = $signed(end_z_reg);
            end
            default:
            begin
                lerp_tag_in.axis = pplmg_pkg::AXIS_X;
            end
        endcase
    end

    pplmg_lerp u_lerp (
        .clk     (clk),
        .rst_n   (rst_n),
        .a       (lerp_a),
        .b       (lerp_b),
        .t       (quot_reg),
        .tag_in  (lerp_tag_in),
        .pos     (lerp_pos),
        .tag_out (lerp_tag_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        start_z_next   = start_z_reg;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        end_z_next     = end_z_reg;
        half_next      = half_reg;
        repeat_next    = repeat_reg;
        phase_next     = phase_reg;
        fwd_next       = fwd_reg;
        passes_next    = passes_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_z_next     = res_z_reg;
        out_valid_next = out_valid_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        pv_next        = pv_reg;
        fin_out_next   = fin_out_reg;

        // register writes restart the motion
        if (cfg_write_en && (cfg_index <= pplmg_pkg::REG_REPEAT_COUNT))
        begin
            case (cfg_index)
                pplmg_pkg::REG_START_X:      start_x_next = cfg_data;
                pplmg_pkg::REG_START_Y:      start_y_next = cfg_data;
                pplmg_pkg::REG_START_Z:      start_z_next = cfg_data;
                pplmg_pkg::REG_END_X:        end_x_next   = cfg_data;
                pplmg_pkg::REG_END_Y:        end_y_next   = cfg_data;
                pplmg_pkg::REG_END_Z:        end_z_next   = cfg_data;
                pplmg_pkg::REG_HALF_PERIOD:  half_next    = cfg_data[23:0];
                pplmg_pkg::REG_REPEAT_COUNT: repeat_next  = cfg_data[15:0];
                default:                     start_x_next = start_x_reg;
            endcase
            phase_next  = '0;
            fwd_next    = 1'b0;
            passes_next = (repeat_next == pplmg_pkg::REPEAT_ENDLESS)
                        ? pplmg_pkg::PASSES_ENDLESS : {1'b0, repeat_next} + 17'd1;
        end

        // lerp results land by axis
        if (lerp_tag_out.vld)
        begin
            case (lerp_tag_out.axis)
                pplmg_pkg::AXIS_X: res_x_next = lerp_pos;
                pplmg_pkg::AXIS_Y: res_y_next = lerp_pos;
                pplmg_pkg::AXIS_Z: res_z_next = lerp_pos;
                default:           res_x_next = res_x_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!endless && (passes_reg == '0))
                    begin
                        fin_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        sum_next   = {1'b0, phase_reg} + {2'b00, elapsed_time};
                        rem_next   = '0;
                        cnt_next   = MOD_LAST;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                rem_next = cs_rem[24:0];
                sum_next = {sum_reg[pplmg_pkg::REM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    phase_next = cs_rem[24:0];
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                rem_next   = num;
                quot_next  = '0;
                cnt_next   = DIV_LAST;
                fin_next   = 1'b0;
                state_next = S_DIV;
                if (dir != fwd_reg)
                begin
                    fwd_next = dir;
                    if (!endless)
                    begin
                        passes_next = passes_reg - 17'd1;
                        if (passes_reg == 17'd1)
                        begin
                            fin_next   = 1'b1;
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_DIV:
            begin
                rem_next  = cs_rem[24:0];
                quot_next = {quot_reg[15:0], cs_ge};
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (lerp_tag_out.vld && (lerp_tag_out.axis == pplmg_pkg::AXIS_Z))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    pv_next        = !fin_reg;
                    fin_out_next   = fin_reg;
                    pos_x_next     = fin_reg ? '0 : res_x_reg;
                    pos_y_next     = fin_reg ? '0 : res_y_reg;
                    pos_z_next     = fin_reg ? '0 : res_z_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_DIV && cnt_reg == '0)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            start_z_reg   <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            end_z_reg     <= '0;
            half_reg      <= pplmg_pkg::HALF_PERIOD_RESET;
            repeat_reg    <= pplmg_pkg::REPEAT_COUNT_RESET;
            phase_reg     <= '0;
            fwd_reg       <= 1'b0;
            passes_reg    <= pplmg_pkg::PASSES_ENDLESS;
            sum_reg       <= '0;
            rem_reg       <= '0;
            quot_reg      <= '0;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            res_z_reg     <= '0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            pv_reg        <= 1'b0;
            fin_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            start_z_reg   <= start_z_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            end_z_reg     <= end_z_next;
            half_reg      <= half_next;
            repeat_reg    <= repeat_next;
            phase_reg     <= phase_next;
            fwd_reg       <= fwd_next;
            passes_reg    <= passes_next;
            sum_reg       <= sum_next;
            rem_reg       <= rem_next;
            quot_reg      <= quot_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            res_x_reg     <= res_x_next;
            res_y_reg     <= res_y_next;
            res_z_reg     <= res_z_next;
            out_valid_reg <= out_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            pos_z_reg     <= pos_z_next;
            pv_reg        <= pv_next;
            fin_out_reg   <= fin_out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pos_x          = $signed(pos_x_reg);
    assign pos_y          = $signed(pos_y_reg);
    assign pos_z          = $signed(pos_z_reg);
    assign position_valid = pv_reg;
    assign finished       = fin_out_reg;

endmodule

// ----- hdl/pplmg_checker.sv -----
// ----------------------------------------------------------------------------
// pplmg_checker
// port-level checks of the ping-pong line motion generator
// ----------------------------------------------------------------------------
`include "ping_pong_line_motion_generator_macros.svh"

module pplmg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic signed [31:0] pos_z,
    input logic               position_valid,
    input logic               finished
);

    // a result is either a position or the end of motion
    `PPLMG_ASSERT_IMPLY(a_kind_exclusive, out_valid, position_valid != finished)

    // end-of-motion results carry a zero position
    `PPLMG_ASSERT_IMPLY(a_finished_zero, out_valid && finished, pos_x == 0 && pos_y == 0 && pos_z == 0)

    // one tick at a time: busy after an input transfer
    `PPLMG_ASSERT_NEXT(a_busy_after_xfer, in_valid && in_ready, !in_ready)

    // a stalled result holds
    `PPLMG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pos_x) && $stable(finished))

endmodule

bind ping_pong_line_motion_generator pplmg_checker u_pplmg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .position_valid (position_valid),
    .finished       (finished)
);
